@@ rtl/core/dph_pkg.sv @@
// Shared types, constants and modular helpers for the double prefix rolling hash.
// No dependencies; imported by the multiply unit and the top level.
package dph_pkg;

  localparam int MAX_LEN = 4096;
  localparam int AW      = $clog2(MAX_LEN);      // prefix store address bits
  localparam int PAW     = $clog2(MAX_LEN + 1);  // power store address bits
  localparam int LEN_W   = 13;
  localparam int HW      = 31;
  localparam int HASH_W  = 63;
  localparam int ENT_W   = 2 * HW;
  localparam int CNT_W   = $clog2(HW);

  typedef logic [HW-1:0] res_t;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_FWD    = 2'd1,
    REQ_REV    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [2:0] CFG_BASE_A     = 3'd0;
  localparam logic [2:0] CFG_MOD_A      = 3'd1;
  localparam logic [2:0] CFG_INV_BASE_A = 3'd2;
  localparam logic [2:0] CFG_BASE_B     = 3'd3;
  localparam logic [2:0] CFG_MOD_B      = 3'd4;
  localparam logic [2:0] CFG_INV_BASE_B = 3'd5;

  typedef enum logic [3:0] {
    OP_RSYM, OP_RBASE, OP_RINV, OP_FWD, OP_PF, OP_REV, OP_POW, OP_IPOW,
    OP_QR, OP_QL, OP_QM, OP_RPW, OP_RMUL
  } op_t;

  typedef struct packed {
    logic start;
    res_t scan;
    res_t addend;
    res_t modulus;
  } mm_req_t;

  typedef struct packed {
    logic done;
    res_t result;
  } mm_rsp_t;

  // x, y already below m
  function automatic res_t add_mod(res_t x, res_t y, res_t m);
    logic [HW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[HW-1:0];
  endfunction

  function automatic res_t sub_mod(res_t x, res_t y, res_t m);
    logic [HW:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    return s[HW-1:0];
  endfunction

endpackage

@@ rtl/core/dph_mulmod.sv @@
// Bit-serial modular multiplier: (scan * addend) mod modulus, one scan bit a cycle.
// Depends on dph_pkg; addend must already be below the modulus.
module dph_mulmod import dph_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  res_t             acc_r, sc_r, ad_r, m_r;
  res_t             acc_nxt;
  logic [HW:0]      dbl, d1, sum, d2, m32;

  always_comb begin
    m32 = {1'b0, m_r};
    dbl = {acc_r, 1'b0};
    d1  = (dbl >= m32) ? dbl - m32 : dbl;
    sum = d1 + {1'b0, ad_r};
    d2  = (sum >= m32) ? sum - m32 : sum;
    acc_nxt = sc_r[HW-1] ? d2[HW-1:0] : d1[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      sc_r  <= req.scan;
      ad_r  <= req.addend;
      m_r   <= req.modulus;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sc_r  <= {sc_r[HW-2:0], 1'b0};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

@@ rtl/core/double_prefix_rolling_hash.sv @@
// Double polynomial rolling hash with prefix range queries.
// Input word: req_type on in_tuser; symbol, left_pos, right_pos on in_tdata.
// Result word: hash_value and stored_length on out_tdata, error flag on out_tuser.
// One result word per input word, in order.
// An append writes the forward and reverse prefix hashes and the next power and
// inverse power; a forward or reverse query reads two prefixes and one power.
// Forward and reverse prefixes share one synchronous memory, powers and inverse
// powers another; both have a registered read.
// All modular products go through one bit-serial multiplier per hash; an append
// needs eight products, a query three, and an error or unknown request none;
// the next word can be taken in the cycle after the result is loaded.
// One word is in work at a time; in_tready is high only while idle.
// The result sits in an output register, so a new word is taken while the
// receiver stalls; the block waits only when a second result would overwrite it.
// Reset (rst_n low, synchronous) empties the string and restores the default
// bases, moduli and inverses; store contents are left as they are.
// Configuration writes are taken in any cycle and belong in idle periods.
module double_prefix_rolling_hash import dph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // symbol[7:0], left_pos[20:8], right_pos[33:21]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // hash_value[62:0], stored_length[75:63]
  output logic [0:0]  out_tuser,  // error[0]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_CHK  = 8'b00000010,
    ST_RD1  = 8'b00000100,
    ST_RD2  = 8'b00001000,
    ST_LAT  = 8'b00010000,
    ST_OP   = 8'b00100000,
    ST_WR   = 8'b01000000,
    ST_DONE = 8'b10000000
  } state_t;

  localparam logic [ENT_W-1:0] ONE_PAIR = {HW'(1), HW'(1)};

  state_t            state_r;
  op_t               op_r;
  logic              started_r;
  req_t              kind_r;
  logic [7:0]        sym_r;
  logic [LEN_W-1:0]  l_r, r_r, len_r;
  logic              err_r, zero_r;
  res_t              base_a_r, mod_a_r, inv_a_r, base_b_r, mod_b_r, inv_b_r;

  res_t              mod_eff [2];
  res_t              one_m   [2];
  res_t              base_l  [2];
  res_t              inv_l   [2];

  res_t              s_r [2], bb_r [2], ib_r [2], f_r [2], rv_r [2];
  res_t              np_r [2], ni_r [2], t_r [2];

  logic [ENT_W-1:0]  q_f1_r, q_r1_r, q_f2_r, q_r2_r, q_pw_r, q_ip_r;

  // prefix entry: {forward, reverse}; power entry: {power, inverse power}
  logic [2*ENT_W-1:0] pre_mem [MAX_LEN];
  logic [2*ENT_W-1:0] pw_mem  [MAX_LEN+1];
  logic [2*ENT_W-1:0] pre_q, pw_q;
  logic [ENT_W-1:0]  fwd_q, rev_q, pw_val, ip_val;
  logic [AW-1:0]     pre_ra;
  logic [PAW-1:0]    pw_ra, pow_wa;
  logic              pw0_r, wr_en;

  mm_req_t           mm_req [2];
  mm_rsp_t           mm_rsp [2];

  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_err_r;
  logic              load_out;
  logic              last_op;
  op_t               next_op;

  function automatic res_t part(logic [ENT_W-1:0] e, int ln);
    return (ln == 1) ? e[ENT_W-1:HW] : e[HW-1:0];
  endfunction

  // lane 1 is hash A, lane 0 is hash B
  always_comb begin
    mod_eff[1] = (mod_a_r == '0) ? HW'(1) : mod_a_r;
    mod_eff[0] = (mod_b_r == '0) ? HW'(1) : mod_b_r;
    one_m[1]   = (mod_a_r > HW'(1)) ? HW'(1) : '0;
    one_m[0]   = (mod_b_r > HW'(1)) ? HW'(1) : '0;
    base_l[1]  = base_a_r;
    base_l[0]  = base_b_r;
    inv_l[1]   = inv_a_r;
    inv_l[0]   = inv_b_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_a_r <= HW'(151);
      mod_a_r  <= HW'(1000000009);
      inv_a_r  <= HW'(913907293);
      base_b_r <= HW'(197);
      mod_b_r  <= HW'(1000000007);
      inv_b_r  <= HW'(969543154);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_A:     base_a_r <= cfg_wdata;
        CFG_MOD_A:      mod_a_r  <= cfg_wdata;
        CFG_INV_BASE_A: inv_a_r  <= cfg_wdata;
        CFG_BASE_B:     base_b_r <= cfg_wdata;
        CFG_MOD_B:      mod_b_r  <= cfg_wdata;
        CFG_INV_BASE_B: inv_b_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // read addresses: first pass in RD1, second prefix read in RD2
  always_comb begin
    if (state_r == ST_RD1) begin
      if (kind_r == REQ_APPEND) pre_ra = AW'(len_r - LEN_W'(1));
      else                      pre_ra = AW'(r_r - LEN_W'(1));
    end else begin
      pre_ra = AW'(l_r - LEN_W'(2));
    end
    // a forward query needs only the inverse power, a reverse one only the power
    case (kind_r)
      REQ_APPEND: pw_ra = PAW'(len_r);
      REQ_FWD:    pw_ra = PAW'(l_r - LEN_W'(1));
      default:    pw_ra = PAW'(r_r - l_r + LEN_W'(1));
    endcase
    pow_wa = PAW'(len_r + LEN_W'(1));
    wr_en  = (state_r == ST_WR);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pre_mem[len_r[AW-1:0]] <= {f_r[1], f_r[0], rv_r[1], rv_r[0]};
      pw_mem[pow_wa]         <= {np_r[1], np_r[0], ni_r[1], ni_r[0]};
    end
    pre_q <= pre_mem[pre_ra];
    pw_q  <= pw_mem[pw_ra];
    pw0_r <= (pw_ra == '0);
  end

  assign fwd_q = pre_q[2*ENT_W-1:ENT_W];
  assign rev_q = pre_q[ENT_W-1:0];

  // entry zero of the power store is one for both hashes
  assign pw_val = pw0_r ? ONE_PAIR : pw_q[2*ENT_W-1:ENT_W];
  assign ip_val = pw0_r ? ONE_PAIR : pw_q[ENT_W-1:0];

  always_comb begin
    next_op = op_r;
    last_op = 1'b0;
    case (op_r)
      OP_RSYM:  next_op = OP_RBASE;
      OP_RBASE: next_op = OP_RINV;
      OP_RINV:  next_op = OP_FWD;
      OP_FWD:   next_op = OP_PF;
      OP_PF:    next_op = OP_REV;
      OP_REV:   next_op = OP_POW;
      OP_POW:   next_op = OP_IPOW;
      OP_QR:    next_op = (kind_r == REQ_FWD) ? OP_QL : OP_RPW;
      OP_QL:    next_op = OP_QM;
      OP_RPW:   next_op = OP_RMUL;
      default:  last_op = 1'b1;
    endcase
  end

  // operand selection for both multipliers
  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      mm_req[ln].start   = (state_r == ST_OP) && !started_r;
      mm_req[ln].modulus = mod_eff[ln];
      mm_req[ln].scan    = '0;
      mm_req[ln].addend  = one_m[ln];
      case (op_r)
        OP_RSYM:  mm_req[ln].scan = HW'(sym_r);
        OP_RBASE: mm_req[ln].scan = base_l[ln];
        OP_RINV:  mm_req[ln].scan = inv_l[ln];
        OP_FWD: begin
          mm_req[ln].scan   = part(q_pw_r, ln);
          mm_req[ln].addend = s_r[ln];
        end
        OP_PF:    mm_req[ln].scan = part(q_f1_r, ln);
        OP_REV: begin
          mm_req[ln].scan   = part(q_r1_r, ln);
          mm_req[ln].addend = bb_r[ln];
        end
        OP_POW: begin
          mm_req[ln].scan   = part(q_pw_r, ln);
          mm_req[ln].addend = bb_r[ln];
        end
        OP_IPOW: begin
          mm_req[ln].scan   = part(q_ip_r, ln);
          mm_req[ln].addend = ib_r[ln];
        end
        OP_QR: mm_req[ln].scan = (kind_r == REQ_FWD) ? part(q_f1_r, ln) : part(q_r1_r, ln);
        OP_QL: mm_req[ln].scan = part(q_f2_r, ln);
        OP_QM: begin
          mm_req[ln].scan   = part(q_ip_r, ln);
          mm_req[ln].addend = f_r[ln];
        end
        OP_RPW: mm_req[ln].scan = part(q_pw_r, ln);
        OP_RMUL: begin
          mm_req[ln].scan   = part(q_r2_r, ln);
          mm_req[ln].addend = t_r[ln];
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    dph_mulmod u_mm (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (mm_req[g]),
      .rsp   (mm_rsp[g])
    );
  end

  // working registers: capture reads and multiplier results
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      kind_r <= req_t'(in_tuser);
      sym_r  <= in_tdata[7:0];
      l_r    <= in_tdata[20:8];
      r_r    <= in_tdata[33:21];
    end
    if (state_r == ST_RD2) begin
      q_f1_r <= fwd_q;
      q_r1_r <= rev_q;
      q_pw_r <= pw_val;
      q_ip_r <= ip_val;
    end
    if (state_r == ST_LAT) begin
      q_f2_r <= fwd_q;
      q_r2_r <= rev_q;
    end
    if (state_r == ST_OP && mm_rsp[1].done) begin
      for (int ln = 0; ln < 2; ln++) begin
        case (op_r)
          OP_RSYM:  s_r[ln]  <= mm_rsp[ln].result;
          OP_RBASE: bb_r[ln] <= mm_rsp[ln].result;
          OP_RINV:  ib_r[ln] <= mm_rsp[ln].result;
          OP_FWD:   f_r[ln]  <= mm_rsp[ln].result;
          OP_PF: begin
            if (len_r != '0) f_r[ln] <= add_mod(mm_rsp[ln].result, f_r[ln], mod_eff[ln]);
          end
          OP_REV: begin
            if (len_r != '0) rv_r[ln] <= add_mod(s_r[ln], mm_rsp[ln].result, mod_eff[ln]);
            else             rv_r[ln] <= s_r[ln];
          end
          OP_POW:   np_r[ln] <= mm_rsp[ln].result;
          OP_IPOW:  ni_r[ln] <= mm_rsp[ln].result;
          OP_QR:    f_r[ln]  <= mm_rsp[ln].result;
          OP_QM:    f_r[ln]  <= mm_rsp[ln].result;
          OP_RPW:   t_r[ln]  <= mm_rsp[ln].result;
          OP_QL, OP_RMUL: begin
            if (l_r > LEN_W'(1)) f_r[ln] <= sub_mod(f_r[ln], mm_rsp[ln].result, mod_eff[ln]);
          end
          default: ;
        endcase
      end
    end
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_RSYM;
      started_r   <= 1'b0;
      len_r       <= '0;
      err_r       <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_CHK;
        end
        ST_CHK: begin
          err_r  <= 1'b0;
          zero_r <= 1'b1;
          state_r <= ST_DONE;
          case (kind_r)
            REQ_APPEND: begin
              if (len_r >= LEN_W'(MAX_LEN)) err_r <= 1'b1;
              else                          state_r <= ST_RD1;
            end
            REQ_FWD, REQ_REV: begin
              if (l_r == '0 || l_r > r_r || r_r > len_r) begin
                err_r <= 1'b1;
              end else begin
                zero_r  <= 1'b0;
                state_r <= ST_RD1;
              end
            end
            default: ;
          endcase
        end
        ST_RD1: state_r <= ST_RD2;
        ST_RD2: state_r <= ST_LAT;
        ST_LAT: begin
          op_r    <= (kind_r == REQ_APPEND) ? OP_RSYM : OP_QR;
          state_r <= ST_OP;
        end
        ST_OP: begin
          if (!started_r) started_r <= 1'b1;
          if (mm_rsp[1].done) begin
            started_r <= 1'b0;
            if (last_op) state_r <= (kind_r == REQ_APPEND) ? ST_WR : ST_DONE;
            else         op_r    <= next_op;
          end
        end
        ST_WR: begin
          len_r   <= len_r + LEN_W'(1);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hash_r <= zero_r ? '0 : {f_r[1], 1'b0, f_r[0]};
      out_err_r  <= err_r;
      out_len_r  <= len_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_len_r, out_hash_r};
  assign out_tuser  = out_err_r;

endmodule

@@ rtl/core/dph_checker.sv @@
// Port-level checks for the double prefix rolling hash, bound to the top level.
// Depends on the top level's port list only.
module dph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_index,
  input logic [30:0] cfg_wdata
);

  // hold a result word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[62:0] == 63'd0)
    else $error("error word carries a hash");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[75:63] <= 13'd4096)
    else $error("stored length beyond capacity");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind double_prefix_rolling_hash dph_checker u_dph_checker (.*);
